FILE: rtl/buht_pkg.sv
// Shared types and constants for the backtrace uniquing hash table.
// Holds the transfer structs, status and command codes, and controller states.
// No dependencies.
package buht_pkg;

  localparam int unsigned ADDR_W   = 36;
  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned NODE_W   = 16;
  localparam int unsigned STRIDE_W = 12;
  localparam int unsigned HASH_W   = 36;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned ENTRY_W  = NODE_W + ADDR_W;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd1394;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [PADDR_W-3:0] REG_PROBE_STRIDE = 1'b0;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_SKIPPED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_READ      = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_STEP,
    S_WRAP,
    S_NODE
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [FRAME_W-1:0] frame_address;
    logic               start_of_stack;
    logic [NODE_W-1:0]  node_index;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [NODE_W-1:0] result_index;
    logic [ADDR_W-1:0] read_address;
    logic [NODE_W-1:0] read_parent;
    logic [NODE_W-1:0] occupied_count;
  } result_t;

endpackage

FILE: rtl/backtrace_uniquing_hash_table.sv
// A read of a bad index and an insert of a zero frame are answered from idle; a node read
// passes through the node state; an insert runs the hash remainder unit, then reads and
// checks each probe slot; a probe index that needs a full wrap goes through the unit again.
// Throughput: one command at a time; node reads and nonzero inserts hold busy until the strobe.
// Reset: a clearing pass writes zero to all SLOT_COUNT entries, one per cycle, with busy high.
// The result strobe lasts one cycle; the receiver cannot stall. Uses buht_pkg, buht_cfg, buht_mod.
module backtrace_uniquing_hash_table #(
  parameter int unsigned SLOT_COUNT = 65536,
  parameter int unsigned MAX_PROBES = 23
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  buht_pkg::item_t               item_i,
  output logic                          result_valid_o,
  output buht_pkg::result_t             result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [buht_pkg::PADDR_W-1:0]  paddr,
  input  logic [buht_pkg::PDATA_W-1:0]  pwdata,
  output logic [buht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned USABLE  = SLOT_COUNT - 1;
  localparam int unsigned CW      = (IDX_W > buht_pkg::NODE_W) ? IDX_W : buht_pkg::NODE_W;
  localparam int unsigned LEFT_W  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int unsigned STEP_W  = LEFT_W + buht_pkg::STRIDE_W + 1;
  localparam int unsigned SUM_W   = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;

  buht_pkg::state_e state_q, state_d;

  logic [buht_pkg::ENTRY_W-1:0] slot_mem_q [SLOT_COUNT];
  logic [buht_pkg::ENTRY_W-1:0] rdata_q;

  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [IDX_W-1:0]             clr_q, clr_d;
  logic [LEFT_W-1:0]            left_q, left_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [buht_pkg::ENTRY_W-1:0] packed_q, packed_d;
  logic [buht_pkg::NODE_W-1:0]  node_q, node_d;
  logic [buht_pkg::NODE_W-1:0]  cur_parent_q, cur_parent_d;
  logic [buht_pkg::NODE_W-1:0]  filled_q, filled_d;
  buht_pkg::result_t            result_q, result_d;
  logic                         result_valid_q, result_valid_d;

  logic                         mem_we, mem_re;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;
  logic [buht_pkg::ENTRY_W-1:0] mem_wdata;

  logic                         mod_start, mod_done;
  logic [buht_pkg::HASH_W-1:0]  mod_operand;
  logic [IDX_W-1:0]             mod_rem;

  logic [buht_pkg::STRIDE_W-1:0] probe_stride;

  logic                         accept;
  logic [buht_pkg::NODE_W-1:0]  parent_eff;
  logic [buht_pkg::ADDR_W-1:0]  addr_clamped;
  logic [buht_pkg::HASH_W-1:0]  hash_value;
  logic [CW-1:0]                node_ext, idx_ext;
  logic                         node_bad;
  logic [buht_pkg::NODE_W-1:0]  idx_node;
  logic                         slot_empty, slot_hit;
  logic                         sum_over, sum_near;
  logic [SUM_W-1:0]             sum_dec, sum_fold;
  logic [STEP_W-1:0]            step_prod;

  buht_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .probe_stride_o (probe_stride)
  );

  buht_mod #(
    .DIVISOR (USABLE),
    .REM_W   (IDX_W),
    .IN_W    (buht_pkg::HASH_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .operand_i (mod_operand),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign busy   = (state_q != buht_pkg::S_IDLE);
  assign accept = start & ~busy;

  assign parent_eff   = item_i.start_of_stack ? '0 : cur_parent_q;
  assign addr_clamped = (|item_i.frame_address[buht_pkg::FRAME_W-1:buht_pkg::ADDR_W]) ?
                        '1 : item_i.frame_address[buht_pkg::ADDR_W-1:0];
  assign hash_value   = buht_pkg::HASH_W'({parent_eff, 4'b0000}) ^
                        buht_pkg::HASH_W'(addr_clamped >> 2);

  assign node_ext = CW'(item_i.node_index);
  assign node_bad = (node_ext == '0) || (node_ext > CW'(USABLE));
  assign idx_ext  = CW'(idx_q);
  assign idx_node = idx_ext[buht_pkg::NODE_W-1:0];

  assign slot_empty = (rdata_q == '0);
  assign slot_hit   = (rdata_q == packed_q);

  assign step_prod = STEP_W'(left_q) * STEP_W'(probe_stride);
  assign sum_over  = (sum_q > SUM_W'(USABLE));
  assign sum_dec   = sum_q - SUM_W'(1);
  assign sum_near  = ({1'b0, sum_dec} < (SUM_W + 1)'(2 * USABLE));
  assign sum_fold  = sum_dec - SUM_W'(USABLE) + SUM_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      buht_pkg::S_CLEAR: begin
        if (clr_q == IDX_W'(SLOT_COUNT - 1)) state_d = buht_pkg::S_IDLE;
      end
      buht_pkg::S_IDLE: begin
        if (accept) begin
          if (item_i.cmd == buht_pkg::CMD_READ) begin
            if (!node_bad) state_d = buht_pkg::S_NODE;
          end else if (item_i.frame_address != '0) begin
            state_d = buht_pkg::S_HASH;
          end
        end
      end
      buht_pkg::S_HASH: begin
        if (mod_done) state_d = buht_pkg::S_READ;
      end
      buht_pkg::S_READ:  state_d = buht_pkg::S_CHECK;
      buht_pkg::S_CHECK: begin
        if (slot_empty || slot_hit || left_q == '0) state_d = buht_pkg::S_IDLE;
        else state_d = buht_pkg::S_STEP;
      end
      buht_pkg::S_STEP: begin
        if (!sum_over || sum_near) state_d = buht_pkg::S_READ;
        else state_d = buht_pkg::S_WRAP;
      end
      buht_pkg::S_WRAP: begin
        if (mod_done) state_d = buht_pkg::S_READ;
      end
      buht_pkg::S_NODE:  state_d = buht_pkg::S_IDLE;
      default:           state_d = buht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d          = idx_q;
    clr_d          = clr_q;
    left_d         = left_q;
    step_d         = step_q;
    sum_d          = sum_q;
    packed_d       = packed_q;
    node_d         = node_q;
    cur_parent_d   = cur_parent_q;
    filled_d       = filled_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = idx_q;
    mem_wdata      = packed_q;
    mem_re         = 1'b0;
    mem_raddr      = idx_q;
    mod_start      = 1'b0;
    mod_operand    = buht_pkg::HASH_W'(sum_dec);
    case (state_q)
      buht_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
      end
      buht_pkg::S_IDLE: begin
        mod_operand = hash_value;
        if (accept) begin
          result_d                = '0;
          result_d.occupied_count = filled_q;
          if (item_i.cmd == buht_pkg::CMD_READ) begin
            node_d = item_i.node_index;
            if (node_bad) begin
              result_d.status = buht_pkg::ST_BAD_INDEX;
              result_valid_d  = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = node_ext[IDX_W-1:0];
            end
          end else begin
            cur_parent_d = parent_eff;
            if (item_i.frame_address == '0) begin
              result_d.status       = buht_pkg::ST_SKIPPED;
              result_d.result_index = parent_eff;
              result_valid_d        = 1'b1;
            end else begin
              packed_d  = {parent_eff, addr_clamped};
              mod_start = 1'b1;
              left_d    = LEFT_W'(MAX_PROBES - 1);
            end
          end
        end
      end
      buht_pkg::S_HASH: begin
        if (mod_done) idx_d = mod_rem + IDX_W'(1);
      end
      buht_pkg::S_READ: begin
        mem_re = 1'b1;
        step_d = step_prod + STEP_W'(1);
      end
      buht_pkg::S_CHECK: begin
        result_d                = '0;
        result_d.occupied_count = filled_q;
        if (slot_empty) begin
          mem_we   = 1'b1;
          filled_d = (filled_q == '1) ? filled_q : filled_q + buht_pkg::NODE_W'(1);
          result_d.status         = buht_pkg::ST_NEW;
          result_d.result_index   = idx_node;
          result_d.occupied_count = filled_d;
          cur_parent_d            = idx_node;
          result_valid_d          = 1'b1;
        end else if (slot_hit) begin
          result_d.status       = buht_pkg::ST_PRESENT;
          result_d.result_index = idx_node;
          cur_parent_d          = idx_node;
          result_valid_d        = 1'b1;
        end else if (left_q == '0) begin
          result_d.status = buht_pkg::ST_FULL;
          cur_parent_d    = '0;
          result_valid_d  = 1'b1;
        end else begin
          left_d = left_q - LEFT_W'(1);
          sum_d  = SUM_W'(idx_q) + SUM_W'(step_q);
        end
      end
      buht_pkg::S_STEP: begin
        if (!sum_over) begin
          idx_d = sum_q[IDX_W-1:0];
        end else if (sum_near) begin
          idx_d = sum_fold[IDX_W-1:0];
        end else begin
          mod_start = 1'b1;
        end
      end
      buht_pkg::S_WRAP: begin
        if (mod_done) idx_d = mod_rem + IDX_W'(1);
      end
      buht_pkg::S_NODE: begin
        result_d                = '0;
        result_d.status         = buht_pkg::ST_READ;
        result_d.result_index   = node_q;
        result_d.read_address   = rdata_q[buht_pkg::ADDR_W-1:0];
        result_d.read_parent    = rdata_q[buht_pkg::ENTRY_W-1:buht_pkg::ADDR_W];
        result_d.occupied_count = filled_q;
        result_valid_d          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= buht_pkg::S_CLEAR;
      clr_q          <= '0;
      cur_parent_q   <= '0;
      filled_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      cur_parent_q   <= cur_parent_d;
      filled_q       <= filled_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    left_q   <= left_d;
    step_q   <= step_d;
    sum_q    <= sum_d;
    packed_q <= packed_d;
    node_q   <= node_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= slot_mem_q[mem_raddr];
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_mem_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == buht_pkg::S_CLEAR || state_q == buht_pkg::S_CHECK))
    else $error("slot write outside clear pass or probe check");

  a_new_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == buht_pkg::ST_NEW) |->
    (filled_q == $past(filled_q) + buht_pkg::NODE_W'(1) || filled_q == '1))
    else $error("new node without occupancy increment");

  a_mod_done_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == buht_pkg::S_HASH || state_q == buht_pkg::S_WRAP))
    else $error("remainder unit finished while not awaited");

  a_probe_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == buht_pkg::S_READ) |-> (idx_q != '0 && idx_q <= IDX_W'(USABLE)))
    else $error("probe index outside usable slots");

endmodule

FILE: rtl/buht_cfg.sv
// APB register block holding the probe stride.
// Depends on buht_pkg.
module buht_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [buht_pkg::PADDR_W-1:0]        paddr,
  input  logic [buht_pkg::PDATA_W-1:0]        pwdata,
  output logic [buht_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output logic [buht_pkg::STRIDE_W-1:0]       probe_stride_o
);

  logic [buht_pkg::STRIDE_W-1:0] probe_stride_q, probe_stride_d;
  logic                          sel_stride;
  logic                          wr_en;

  assign pready     = 1'b1;
  assign sel_stride = (paddr[buht_pkg::PADDR_W-1:2] == buht_pkg::REG_PROBE_STRIDE);
  assign wr_en      = psel & penable & pwrite & pready;

  always_comb begin
    probe_stride_d = probe_stride_q;
    if (wr_en && sel_stride) begin
      probe_stride_d = pwdata[buht_pkg::STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_stride_q <= buht_pkg::STRIDE_RESET;
    end else begin
      probe_stride_q <= probe_stride_d;
    end
  end

  assign prdata         = sel_stride ? buht_pkg::PDATA_W'(probe_stride_q) : '0;
  assign probe_stride_o = probe_stride_q;

endmodule

FILE: rtl/buht_mod.sv
// Digit-serial remainder unit: operand modulo a fixed divisor, four bits a cycle.
// Depends on buht_pkg.
module buht_mod #(
  parameter int unsigned DIVISOR = 65535,
  parameter int unsigned REM_W   = 16,
  parameter int unsigned IN_W    = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  operand_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam int unsigned DIGITS = IN_W / buht_pkg::DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
  localparam logic [REM_W:0] DIV = (REM_W + 1)'(DIVISOR);

  logic [IN_W-1:0]  shift_q, shift_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [REM_W:0]   acc;

  always_comb begin
    acc = {1'b0, rem_q};
    for (int k = 0; k < buht_pkg::DIGIT_W; k++) begin
      acc = {acc[REM_W-1:0], shift_q[IN_W-1-k]};
      if (acc >= DIV) begin
        acc = acc - DIV;
      end
    end
  end

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = (cnt_q == CNT_W'(1));
    if (start_i) begin
      shift_d = operand_i;
      rem_d   = '0;
      cnt_d   = CNT_W'(DIGITS);
    end else if (cnt_q != '0) begin
      shift_d = shift_q << buht_pkg::DIGIT_W;
      rem_d   = acc[REM_W-1:0];
      cnt_d   = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
